>>> rtl/core/pagerank_residual_vertex_update_top_defines.svh
// Assertion macros for the PageRank residual vertex update block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef PAGERANK_RESIDUAL_VERTEX_UPDATE_TOP_DEFINES_SVH
`define PAGERANK_RESIDUAL_VERTEX_UPDATE_TOP_DEFINES_SVH

// checked out of reset only
`define PRVU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// checked at every edge, reset included
`define PRVU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`endif

>>> rtl/core/prvu_pkg.sv
// Shared widths, reset values and codes of the PageRank residual vertex update.
// No dependencies.
package prvu_pkg;

  localparam int VALUE_W   = 32;
  localparam int WEIGHT_W  = 29;
  localparam int DRAW_W    = 16;
  localparam int DEGREE_W  = 16;
  localparam int ACC_W     = 40;
  localparam int FRAC_W    = 28;
  localparam int MUL_W     = 32;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CFG_IDX_W = 4;
  localparam int STEP_W    = 3;

  localparam logic [WEIGHT_W-1:0] ONE_Q      = WEIGHT_W'(1) << FRAC_W;
  localparam logic [WEIGHT_W-1:0] JUMP_RESET = WEIGHT_W'(26843546);
  localparam logic [VALUE_W-1:0]  PREC_RESET = VALUE_W'(1);

  // item kinds
  localparam logic [1:0] MODE_BEGIN   = 2'd0;
  localparam logic [1:0] MODE_IN_EDGE = 2'd1;
  localparam logic [1:0] MODE_END     = 2'd2;
  localparam logic [1:0] MODE_OUT_EDGE = 2'd3;

  // scheduling rules
  localparam logic [1:0] SCHED_RANDOM    = 2'd0;
  localparam logic [1:0] SCHED_ALWAYS    = 2'd1;
  localparam logic [1:0] SCHED_DEGREE    = 2'd2;
  localparam logic [1:0] SCHED_THRESHOLD = 2'd3;

  // result kinds
  localparam logic KIND_VALUE = 1'b0;
  localparam logic KIND_EDGE  = 1'b1;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_WEIGHT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_PER_VERTEX = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_PREC     = CFG_IDX_W'(3);

endpackage

>>> rtl/core/prvu_mul.sv
// Shared unsigned 32x32 multiplier with registered product and load enable.
// Depends on prvu_pkg.
module prvu_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [prvu_pkg::MUL_W-1:0]    a_i,
  input  logic [prvu_pkg::MUL_W-1:0]    b_i,
  output logic [prvu_pkg::PROD_W-1:0]   prod_o
);

  logic [prvu_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prvu_pkg::PROD_W'(a_i) * prvu_pkg::PROD_W'(b_i);
    end
  end

  assign prod_o = prod_q;

endmodule

>>> rtl/core/pagerank_residual_vertex_update_top.sv
// Each item is accepted in idle, then steps through the shared multiplier; end and out-edge
// items give a result, which shows as the block returns to idle for the next item.
// The number of steps is set by the number of products through the one shared 32x32 multiplier.
// A stalled output only holds the final step; the next item is taken while a result waits.
// Reset is asynchronous, active low: registers return to defaults, state to idle, step to zero.
module pagerank_residual_vertex_update_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        mode_i,
  input  logic [prvu_pkg::VALUE_W-1:0]      vertex_value_i,
  input  logic [prvu_pkg::WEIGHT_W-1:0]     self_weight_i,
  input  logic [prvu_pkg::WEIGHT_W-1:0]     edge_weight_i,
  input  logic [prvu_pkg::VALUE_W-1:0]      source_value_i,
  input  logic [prvu_pkg::VALUE_W-1:0]      last_used_value_i,
  input  logic [prvu_pkg::DRAW_W-1:0]       random_draw_i,
  input  logic [prvu_pkg::DEGREE_W-1:0]     target_in_degree_i,
  input  logic [prvu_pkg::WEIGHT_W-1:0]     target_self_weight_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              result_kind_o,
  output logic [prvu_pkg::VALUE_W-1:0]      new_value_o,
  output logic [prvu_pkg::VALUE_W-1:0]      edge_residual_o,
  output logic                              schedule_target_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [prvu_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [prvu_pkg::VALUE_W-1:0]      cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_BUSY = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [prvu_pkg::STEP_W-1:0] step_q, step_d;

  logic [prvu_pkg::WEIGHT_W-1:0] jump_weight_q, jump_per_vertex_q;
  logic [1:0]                    sched_mode_q;
  logic [prvu_pkg::VALUE_W-1:0]  target_prec_q;

  logic [1:0]                     mode_q;
  logic [prvu_pkg::VALUE_W-1:0]   vval_q, src_q, diff_q;
  logic [prvu_pkg::WEIGHT_W-1:0]  sw_q, ew_q, tsw_q;
  logic [prvu_pkg::DRAW_W-1:0]    draw_q;
  logic [prvu_pkg::DEGREE_W-1:0]  deg_q;

  logic [prvu_pkg::ACC_W-1:0]     acc_q;
  logic [prvu_pkg::VALUE_W-1:0]   updated_q;
  logic [prvu_pkg::DRAW_W-1:0]    latched_draw_q;

  logic [prvu_pkg::PROD_W-1:0]    t_q;
  logic [prvu_pkg::ACC_W:0]       d_q;
  logic [prvu_pkg::VALUE_W-1:0]   res_q;
  logic [29:0]                    scaled_q;
  logic [60:0]                    n_q, b_q;

  logic                           out_valid_q, kind_q, sched_q;
  logic [prvu_pkg::VALUE_W-1:0]   new_value_q, residual_q;

  logic                           accept, busy, emits, is_last, out_free, advance, emit;
  logic [prvu_pkg::STEP_W-1:0]    last_step;
  logic [prvu_pkg::WEIGHT_W-1:0]  one_minus_jump, denom;
  logic [prvu_pkg::MUL_W-1:0]     mul_a, mul_b;
  logic [prvu_pkg::PROD_W-1:0]    prod;
  logic [prvu_pkg::VALUE_W-1:0]   diff_d;

  logic [prvu_pkg::ACC_W:0]       acc_sum;
  logic [prvu_pkg::ACC_W-1:0]     acc_add;
  logic [prvu_pkg::ACC_W:0]       d_new;
  logic [prvu_pkg::ACC_W+1:0]     nv_sum;
  logic [prvu_pkg::VALUE_W-1:0]   nv, res_sat;
  logic [35:0]                    res_full;
  logic [76:0]                    lhs_wide;
  logic                           rnd_ok, thr_ok, deg_ok, flag;

  assign busy        = (state_q == ST_BUSY);
  assign in_stall_o  = !(state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign accept      = in_valid_i && (state_q == ST_IDLE);

  assign one_minus_jump = (jump_weight_q >= prvu_pkg::ONE_Q) ? '0
                                                              : prvu_pkg::ONE_Q - jump_weight_q;
  assign denom = prvu_pkg::ONE_Q - scaled_q[prvu_pkg::WEIGHT_W-1:0];

  assign diff_d = (last_used_value_i >= updated_q) ? last_used_value_i - updated_q
                                                   : updated_q - last_used_value_i;

  always_comb begin
    last_step = prvu_pkg::STEP_W'(1);
    emits     = 1'b0;
    case (mode_q)
      prvu_pkg::MODE_END: begin
        last_step = prvu_pkg::STEP_W'(3);
        emits     = 1'b1;
      end
      prvu_pkg::MODE_OUT_EDGE: begin
        last_step = (sched_mode_q == prvu_pkg::SCHED_DEGREE) ? prvu_pkg::STEP_W'(6)
                                                             : prvu_pkg::STEP_W'(2);
        emits     = 1'b1;
      end
      default: begin
        last_step = prvu_pkg::STEP_W'(1);
        emits     = 1'b0;
      end
    endcase
  end

  assign is_last  = (step_q == last_step);
  assign out_free = !out_valid_q || !out_stall_i;
  assign advance  = busy && !(is_last && emits && !out_free);
  assign emit     = advance && is_last && emits;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mode_q)
      prvu_pkg::MODE_BEGIN: begin
        mul_a = vval_q;
        mul_b = prvu_pkg::MUL_W'(sw_q);
      end
      prvu_pkg::MODE_IN_EDGE: begin
        mul_a = prvu_pkg::MUL_W'(ew_q);
        mul_b = src_q;
      end
      prvu_pkg::MODE_END: begin
        mul_a = prvu_pkg::MUL_W'(one_minus_jump);
        mul_b = (step_q == prvu_pkg::STEP_W'(0)) ? acc_q[31:0]
                                                 : prvu_pkg::MUL_W'(acc_q[39:32]);
      end
      default: begin
        case (step_q)
          prvu_pkg::STEP_W'(0): begin
            mul_a = prvu_pkg::MUL_W'(ew_q);
            mul_b = diff_q;
          end
          prvu_pkg::STEP_W'(1): begin
            if (sched_mode_q == prvu_pkg::SCHED_DEGREE) begin
              mul_a = prvu_pkg::MUL_W'(one_minus_jump);
              mul_b = prvu_pkg::MUL_W'(tsw_q);
            end else begin
              mul_a = prvu_pkg::MUL_W'(latched_draw_q);
              mul_b = target_prec_q;
            end
          end
          prvu_pkg::STEP_W'(2): begin
            mul_a = prvu_pkg::MUL_W'(one_minus_jump);
            mul_b = res_q;
          end
          prvu_pkg::STEP_W'(3): begin
            mul_a = target_prec_q;
            mul_b = prvu_pkg::MUL_W'(denom);
          end
          prvu_pkg::STEP_W'(4): begin
            mul_a = n_q[31:0];
            mul_b = prvu_pkg::MUL_W'(deg_q);
          end
          prvu_pkg::STEP_W'(5): begin
            mul_a = prvu_pkg::MUL_W'(n_q[60:32]);
            mul_b = prvu_pkg::MUL_W'(deg_q);
          end
          default: begin
            mul_a = '0;
            mul_b = '0;
          end
        endcase
      end
    endcase
  end

  prvu_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (advance),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // datapath around the product
  assign acc_sum  = {1'b0, acc_q} + (prvu_pkg::ACC_W + 1)'(prod[63:28]);
  assign acc_add  = acc_sum[prvu_pkg::ACC_W] ? '1 : acc_sum[prvu_pkg::ACC_W-1:0];
  assign d_new    = {1'b0, prod[35:0], 4'b0000} + (prvu_pkg::ACC_W + 1)'(t_q[63:28]);
  assign nv_sum   = {1'b0, d_q} + (prvu_pkg::ACC_W + 2)'(jump_per_vertex_q);
  assign nv       = (|nv_sum[prvu_pkg::ACC_W+1:prvu_pkg::VALUE_W]) ? '1
                                                                 : nv_sum[31:0];
  assign res_full = prod[63:28];
  assign res_sat  = (|res_full[35:32]) ? '1 : res_full[31:0];
  assign lhs_wide = {prod[44:0], 32'b0} + 77'(t_q[47:0]);

  assign rnd_ok = {res_q, 16'b0} >= prod[47:0];
  assign thr_ok = res_q > target_prec_q;
  assign deg_ok = (|scaled_q[29:28]) ? ((n_q != '0) && (deg_q != '0))
                                     : (lhs_wide >= 77'(b_q));

  always_comb begin
    case (sched_mode_q)
      prvu_pkg::SCHED_RANDOM: flag = rnd_ok;
      prvu_pkg::SCHED_ALWAYS: flag = 1'b1;
      prvu_pkg::SCHED_DEGREE: flag = deg_ok;
      default:                flag = thr_ok;
    endcase
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_BUSY;
          step_d  = '0;
        end
      end
      ST_BUSY: begin
        if (advance) begin
          if (is_last) begin
            state_d = ST_IDLE;
          end else begin
            step_d = step_q + prvu_pkg::STEP_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jump_weight_q     <= prvu_pkg::JUMP_RESET;
      jump_per_vertex_q <= prvu_pkg::JUMP_RESET;
      sched_mode_q      <= prvu_pkg::SCHED_RANDOM;
      target_prec_q     <= prvu_pkg::PREC_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        prvu_pkg::REG_JUMP_WEIGHT:     jump_weight_q     <= cfg_data_i[prvu_pkg::WEIGHT_W-1:0];
        prvu_pkg::REG_JUMP_PER_VERTEX: jump_per_vertex_q <= cfg_data_i[prvu_pkg::WEIGHT_W-1:0];
        prvu_pkg::REG_SCHED_MODE:      sched_mode_q      <= cfg_data_i[1:0];
        prvu_pkg::REG_TARGET_PREC:     target_prec_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      vval_q <= vertex_value_i;
      sw_q   <= self_weight_i;
      ew_q   <= edge_weight_i;
      src_q  <= source_value_i;
      diff_q <= diff_d;
      draw_q <= random_draw_i;
      deg_q  <= target_in_degree_i;
      tsw_q  <= target_self_weight_i;
    end
  end

  // vertex state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q          <= '0;
      updated_q      <= '0;
      latched_draw_q <= '0;
    end else if (advance) begin
      if (mode_q == prvu_pkg::MODE_BEGIN && step_q == prvu_pkg::STEP_W'(1)) begin
        acc_q <= prvu_pkg::ACC_W'(prod[63:28]);
      end
      if (mode_q == prvu_pkg::MODE_IN_EDGE && step_q == prvu_pkg::STEP_W'(1)) begin
        acc_q <= acc_add;
      end
      if (mode_q == prvu_pkg::MODE_END && step_q == prvu_pkg::STEP_W'(3)) begin
        updated_q      <= nv;
        latched_draw_q <= draw_q;
      end
    end
  end

  // intermediates
  always_ff @(posedge clk_i) begin
    if (advance) begin
      case (mode_q)
        prvu_pkg::MODE_END: begin
          if (step_q == prvu_pkg::STEP_W'(1)) t_q <= prod;
          if (step_q == prvu_pkg::STEP_W'(2)) d_q <= d_new;
        end
        prvu_pkg::MODE_OUT_EDGE: begin
          if (step_q == prvu_pkg::STEP_W'(1)) res_q    <= res_sat;
          if (step_q == prvu_pkg::STEP_W'(2)) scaled_q <= prod[57:28];
          if (step_q == prvu_pkg::STEP_W'(3)) n_q      <= prod[60:0];
          if (step_q == prvu_pkg::STEP_W'(4)) b_q      <= prod[60:0];
          if (step_q == prvu_pkg::STEP_W'(5)) t_q      <= prod;
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (mode_q == prvu_pkg::MODE_END) begin
        kind_q      <= prvu_pkg::KIND_VALUE;
        new_value_q <= nv;
        residual_q  <= '0;
        sched_q     <= 1'b0;
      end else begin
        kind_q      <= prvu_pkg::KIND_EDGE;
        new_value_q <= updated_q;
        residual_q  <= res_q;
        sched_q     <= flag;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = kind_q;
  assign new_value_o       = new_value_q;
  assign edge_residual_o   = residual_q;
  assign schedule_target_o = sched_q;

endmodule

>>> rtl/core/prvu_chk.sv
// Port-level checker for the PageRank residual vertex update top level.
// Depends on prvu_pkg and the assertion macro header; bound to the top below.
`include "pagerank_residual_vertex_update_top_defines.svh"

module prvu_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          result_kind_o,
  input logic [prvu_pkg::VALUE_W-1:0]  new_value_o,
  input logic [prvu_pkg::VALUE_W-1:0]  edge_residual_o,
  input logic                          schedule_target_o
);

  // every accepted item occupies the shared multiplier, so the input stalls after it is taken
  `PRVU_ASSERT(a_busy_after_beat, in_valid_i && !in_stall_o |=> in_stall_o, "input taken while busy")

  `PRVU_ASSERT(a_value_beat_clean, out_valid_o && result_kind_o == prvu_pkg::KIND_VALUE |-> edge_residual_o == '0 && !schedule_target_o, "value beat carries edge fields")

  `PRVU_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o && !in_stall_o, "not idle in reset")

  `PRVU_ASSERT(a_out_valid_holds, out_valid_o && out_stall_i |=> out_valid_o, "output beat dropped")

  `PRVU_ASSERT(a_out_payload_holds, out_valid_o && out_stall_i |=> $stable(new_value_o) && $stable(edge_residual_o) && $stable(result_kind_o) && $stable(schedule_target_o), "stalled output changed")

endmodule

bind pagerank_residual_vertex_update_top prvu_chk u_prvu_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .result_kind_o     (result_kind_o),
  .new_value_o       (new_value_o),
  .edge_residual_o   (edge_residual_o),
  .schedule_target_o (schedule_target_o)
);

>>> tb/sv/pagerank_residual_vertex_update_top_tb.sv
// Self-checking bench for pagerank_residual_vertex_update_top: a directed table, then
// random vertex streams under several register settings, checked against a local predictor.
// Depends on prvu_pkg and the block's RTL only.
module pagerank_residual_vertex_update_top_tb;
  import prvu_pkg::*;

  localparam int unsigned PHASES          = 12;
  localparam int unsigned ITEMS_PER_PHASE = 75;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned CYCLE_LIMIT     = 600000;

  localparam logic [VALUE_W-1:0]  VMAX    = '1;
  localparam logic [WEIGHT_W-1:0] WMAX    = '1;
  localparam logic [VALUE_W-1:0]  VONE    = VALUE_W'(ONE_Q);
  localparam logic [63:0]         ACC_MAX = (64'd1 << ACC_W) - 64'd1;

  typedef struct packed {
    logic [1:0]          mode;
    logic [VALUE_W-1:0]  vertex_value;
    logic [WEIGHT_W-1:0] self_weight;
    logic [WEIGHT_W-1:0] edge_weight;
    logic [VALUE_W-1:0]  source_value;
    logic [VALUE_W-1:0]  last_used_value;
    logic [DRAW_W-1:0]   random_draw;
    logic [DEGREE_W-1:0] target_in_degree;
    logic [WEIGHT_W-1:0] target_self_weight;
  } vertex_item_t;

  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] new_value;
    logic [VALUE_W-1:0] edge_residual;
    logic               sched;
  } rank_result_t;

  typedef struct packed {
    vertex_item_t item;
    logic         typed;
    rank_result_t want;
  } directed_row_t;

  localparam rank_result_t NO_RESULT = '0;

  // mode, vertex_value, self_weight, edge_weight, source_value, last_used, draw, degree, tsw
  localparam int unsigned DIRECTED_COUNT = 22;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{'{MODE_END, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1,
      '{KIND_VALUE, 32'(JUMP_RESET), 0, 1'b0}},
    '{'{MODE_OUT_EDGE, 0, 0, ONE_Q, 0, 0, 0, 0, 0}, 1'b1,
      '{KIND_EDGE, 32'(JUMP_RESET), 32'(JUMP_RESET), 1'b1}},
    '{'{MODE_IN_EDGE, 0, 0, ONE_Q, VONE, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_END, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_OUT_EDGE, 0, 0, WMAX, 0, VMAX, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_BEGIN, VMAX, WMAX, 0, 0, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_IN_EDGE, 0, 0, WMAX, VMAX, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_END, 0, 0, 0, 0, 0, 16'hFFFF, 0, 0}, 1'b1, '{KIND_VALUE, VMAX, 0, 1'b0}},
    '{'{MODE_OUT_EDGE, 0, 0, WMAX, 0, 0, 0, 0, 0}, 1'b1, '{KIND_EDGE, VMAX, VMAX, 1'b1}},
    '{'{MODE_OUT_EDGE, 0, 0, 0, 0, VMAX, 0, 0, 0}, 1'b1, '{KIND_EDGE, VMAX, 0, 1'b0}},
    '{'{MODE_OUT_EDGE, 0, 0, ONE_Q, 0, VMAX, 16'hFFFF, 16'hFFFF, WMAX}, 1'b1,
      '{KIND_EDGE, VMAX, 0, 1'b0}},
    '{'{MODE_BEGIN, 0, 0, WMAX, VMAX, VMAX, 16'hFFFF, 16'hFFFF, WMAX}, 1'b0, NO_RESULT},
    '{'{MODE_END, 0, 0, 0, 0, 0, 16'd1, 0, 0}, 1'b1,
      '{KIND_VALUE, 32'(JUMP_RESET), 0, 1'b0}},
    '{'{MODE_BEGIN, VONE, ONE_Q, 0, 0, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_IN_EDGE, 0, 0, ONE_Q >> 1, 32'h3000_0000, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_IN_EDGE, 0, 0, 0, VMAX, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_IN_EDGE, 0, 0, ONE_Q, 0, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_END, 0, 0, 0, 0, 0, 16'h8000, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_OUT_EDGE, 0, 0, ONE_Q >> 2, 0, VONE, 0, 16'hFFFF, WMAX}, 1'b0, NO_RESULT},
    '{'{MODE_OUT_EDGE, 0, 0, 1, 0, 1, 0, 1, ONE_Q}, 1'b0, NO_RESULT},
    '{'{MODE_BEGIN, 32'h1234_5678, 29'h0ABC_DEF0, 0, 0, 0, 0, 0, 0}, 1'b0, NO_RESULT},
    '{'{MODE_OUT_EDGE, 0, 0, 29'h0800_0000, 0, 32'h2000_0000, 0, 16'd3, 29'h0400_0000},
      1'b0, NO_RESULT}
  };

  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b1;
  logic                in_valid_i           = 1'b0;
  logic                in_stall_o;
  logic [1:0]          mode_i               = MODE_BEGIN;
  logic [VALUE_W-1:0]  vertex_value_i       = '0;
  logic [WEIGHT_W-1:0] self_weight_i        = '0;
  logic [WEIGHT_W-1:0] edge_weight_i        = '0;
  logic [VALUE_W-1:0]  source_value_i       = '0;
  logic [VALUE_W-1:0]  last_used_value_i    = '0;
  logic [DRAW_W-1:0]   random_draw_i        = '0;
  logic [DEGREE_W-1:0] target_in_degree_i   = '0;
  logic [WEIGHT_W-1:0] target_self_weight_i = '0;
  logic                out_valid_o;
  logic                out_stall_i          = 1'b0;
  logic                result_kind_o;
  logic [VALUE_W-1:0]  new_value_o;
  logic [VALUE_W-1:0]  edge_residual_o;
  logic                schedule_target_o;
  logic                cfg_valid_i          = 1'b0;
  logic                cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i         = '0;
  logic [VALUE_W-1:0]  cfg_data_i           = '0;

  // predictor copy of registers and vertex state
  logic [WEIGHT_W-1:0] cfg_jump  = JUMP_RESET;
  logic [WEIGHT_W-1:0] cfg_jpv   = JUMP_RESET;
  logic [1:0]          cfg_sched = SCHED_RANDOM;
  logic [VALUE_W-1:0]  cfg_prec  = PREC_RESET;
  logic [ACC_W-1:0]    rank_acc  = '0;
  logic [VALUE_W-1:0]  vertex_value_q = '0;
  logic [DRAW_W-1:0]   draw_q    = '0;

  rank_result_t due_results [$];
  rank_result_t head;
  int unsigned  fail_count = 0;
  int unsigned  items_sent = 0;
  int unsigned  value_beats = 0;
  int unsigned  edge_beats = 0;
  int unsigned  scheduled_beats = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  int unsigned  calm_left = 0;
  int unsigned  stall_roll;
  bit           in_calm = 1'b0;

  pagerank_residual_vertex_update_top DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> FRAC_W;
    return (p[127:64] != 0) ? '1 : p[63:0];
  endfunction

  function automatic logic [63:0] keep_fraction();
    return (cfg_jump >= ONE_Q) ? 64'd0 : 64'(ONE_Q) - 64'(cfg_jump);
  endfunction

  function automatic bit schedule_decision(logic [63:0] resid, logic [63:0] deg,
                                           logic [63:0] tsw);
    logic [63:0]  om;
    logic [63:0]  scaled;
    logic [127:0] num;
    logic [127:0] lhs;
    logic [127:0] rhs;
    case (cfg_sched)
      SCHED_RANDOM: begin
        return (128'(resid) << DRAW_W) >= 128'(draw_q) * 128'(cfg_prec);
      end
      SCHED_ALWAYS: begin
        return 1'b1;
      end
      SCHED_DEGREE: begin
        om = keep_fraction();
        scaled = fx_mul(om, tsw);
        num = 128'(om) * 128'(resid);
        // target damping term at or below zero
        if (scaled >= 64'(ONE_Q)) return (num != 0) && (deg != 0);
        if (num[127:64] != 0) return 1'b1;
        lhs = 128'(num[63:0]) * 128'(deg);
        rhs = 128'(cfg_prec) * 128'(64'(ONE_Q) - scaled);
        return lhs >= rhs;
      end
      default: begin
        return resid > 64'(cfg_prec);
      end
    endcase
  endfunction

  task automatic update_rank(vertex_item_t it, bit typed, rank_result_t want);
    logic [63:0]        prod;
    logic [VALUE_W-1:0] diff;
    rank_result_t       calc;
    calc = '0;
    case (it.mode)
      MODE_BEGIN: begin
        prod = fx_mul(it.vertex_value, it.self_weight);
        rank_acc = (prod > ACC_MAX) ? {ACC_W{1'b1}} : prod[ACC_W-1:0];
      end
      MODE_IN_EDGE: begin
        prod = fx_mul(it.edge_weight, it.source_value);
        if (prod >= ACC_MAX - 64'(rank_acc)) rank_acc = {ACC_W{1'b1}};
        else rank_acc = rank_acc + prod[ACC_W-1:0];
      end
      MODE_END: begin
        prod = fx_mul(keep_fraction(), 64'(rank_acc));
        vertex_value_q = (prod > 64'(VMAX) - 64'(cfg_jpv)) ? VMAX
                                                         : VALUE_W'(prod + 64'(cfg_jpv));
        draw_q = it.random_draw;
        calc = '{KIND_VALUE, vertex_value_q, '0, 1'b0};
      end
      default: begin
        diff = (it.last_used_value >= vertex_value_q) ? it.last_used_value - vertex_value_q
                                                      : vertex_value_q - it.last_used_value;
        prod = fx_mul(it.edge_weight, diff);
        if (prod > 64'(VMAX)) prod = 64'(VMAX);
        calc = '{KIND_EDGE, vertex_value_q, prod[VALUE_W-1:0],
                 schedule_decision(prod, it.target_in_degree, it.target_self_weight)};
      end
    endcase
    if (it.mode == MODE_END || it.mode == MODE_OUT_EDGE)
      due_results.push_back(typed ? want : calc);
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2, 3: return VALUE_W'($urandom_range(0, 2 * ONE_Q));
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ONE_Q;
      2: return '1;
      3, 4, 5: return WEIGHT_W'($urandom_range(0, ONE_Q));
      default: return WEIGHT_W'($urandom());
    endcase
  endfunction

  function automatic logic [VALUE_W-1:0] rand_prec();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return PREC_RESET;
      2: return '1;
      3: return VALUE_W'($urandom_range(0, ONE_Q >> 6));
      4: return VALUE_W'($urandom_range(0, ONE_Q));
      default: return VALUE_W'($urandom());
    endcase
  endfunction

  function automatic vertex_item_t rand_item();
    vertex_item_t it;
    it.mode               = 2'($urandom_range(0, 3));
    it.vertex_value       = rand_value();
    it.self_weight        = rand_weight();
    it.edge_weight        = rand_weight();
    it.source_value       = rand_value();
    it.last_used_value    = rand_value();
    it.random_draw        = ($urandom_range(0, 5) == 0) ? '1 : DRAW_W'($urandom());
    it.target_in_degree   = ($urandom_range(0, 3) == 0) ? DEGREE_W'($urandom_range(0, 2))
                                                        : DEGREE_W'($urandom());
    it.target_self_weight = rand_weight();
    return it;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (in_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_item(vertex_item_t it, bit typed, rank_result_t want);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i           <= 1'b1;
    mode_i               <= it.mode;
    vertex_value_i       <= it.vertex_value;
    self_weight_i        <= it.self_weight;
    edge_weight_i        <= it.edge_weight;
    source_value_i       <= it.source_value;
    last_used_value_i    <= it.last_used_value;
    random_draw_i        <= it.random_draw;
    target_in_degree_i   <= it.target_in_degree;
    target_self_weight_i <= it.target_self_weight;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    update_rank(it, typed, want);
    items_sent++;
  endtask

  // one vertex: begin, in-edges, end, out-edges; some streams broken or pure noise
  task automatic send_vertex(bit flood);
    vertex_item_t it;
    int unsigned  n_in;
    int unsigned  n_out;
    in_calm = ($urandom_range(0, 5) == 0);
    if (!flood && $urandom_range(0, 9) == 0) begin
      send_item(rand_item(), 1'b0, NO_RESULT);
    end else begin
      if (flood || $urandom_range(0, 9) != 0) begin
        it = rand_item();
        it.mode = MODE_BEGIN;
        send_item(it, 1'b0, NO_RESULT);
      end
      n_in = flood ? $urandom_range(130, 145) : $urandom_range(0, 5);
      repeat (n_in) begin
        it = rand_item();
        it.mode = MODE_IN_EDGE;
        if (flood) begin
          it.edge_weight = WMAX;
          it.source_value = VMAX;
        end
        send_item(it, 1'b0, NO_RESULT);
      end
      if ($urandom_range(0, 19) != 0) begin
        it = rand_item();
        it.mode = MODE_END;
        send_item(it, 1'b0, NO_RESULT);
      end
      n_out = $urandom_range(0, 5);
      repeat (n_out) begin
        it = rand_item();
        it.mode = MODE_OUT_EDGE;
        if ($urandom_range(0, 3) == 0)
          it.last_used_value = vertex_value_q + VALUE_W'($urandom_range(0, 64)) - 32;
        send_item(it, 1'b0, NO_RESULT);
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_JUMP_WEIGHT:     cfg_jump  = data[WEIGHT_W-1:0];
      REG_JUMP_PER_VERTEX: cfg_jpv   = data[WEIGHT_W-1:0];
      REG_SCHED_MODE:      cfg_sched = data[1:0];
      REG_TARGET_PREC:     cfg_prec  = data;
      default: ;
    endcase
  endtask

  // begin and in-edge beats give no result, so allow the pipe to empty afterwards
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] seen);
    if (seen !== want) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result beat with no result due");
        fail_count++;
      end else begin
        head = due_results.pop_front();
        check_field("result_kind", head.kind, result_kind_o);
        check_field("new_value", head.new_value, new_value_o);
        check_field("edge_residual", head.edge_residual, edge_residual_o);
        check_field("schedule_target", head.sched, schedule_target_o);
        if (head.kind == KIND_VALUE) value_beats++;
        else edge_beats++;
        if (head.sched) scheduled_beats++;
      end
    end
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (calm_left != 0) begin
      out_stall_i <= 1'b0;
      calm_left--;
    end else begin
      stall_roll = $urandom_range(0, 99);
      out_stall_i <= (stall_roll >= 3 && stall_roll < 30);
      if (stall_roll < 3) calm_left = $urandom_range(20, 80);
      else if (stall_roll < 27) stall_left = $urandom_range(0, 2);
      else if (stall_roll < 30) stall_left = $urandom_range(8, 30);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
             due_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int unsigned         row;
    int unsigned         phase;
    int unsigned         phase_start;
    logic [WEIGHT_W-1:0] jw;
    logic [WEIGHT_W-1:0] jv;
    logic [1:0]          sm;
    logic [VALUE_W-1:0]  pr;
    rst_ni <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    for (row = 0; row < DIRECTED_COUNT; row++)
      send_item(DIRECTED_ROWS[row].item, DIRECTED_ROWS[row].typed, DIRECTED_ROWS[row].want);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          jw = '0; jv = '0; sm = SCHED_DEGREE; pr = PREC_RESET;
        end
        1: begin
          jw = WMAX; jv = WMAX; sm = SCHED_RANDOM; pr = '1;
        end
        2: begin
          jw = ONE_Q; jv = ONE_Q; sm = SCHED_THRESHOLD; pr = '0;
        end
        3: begin
          // tiny damping factor so a saturated accumulator shows in new_value
          jw = ONE_Q - WEIGHT_W'(4096); jv = rand_weight(); sm = SCHED_RANDOM;
          pr = rand_prec();
        end
        4: begin
          jw = rand_weight(); jv = rand_weight(); sm = SCHED_ALWAYS; pr = rand_prec();
        end
        default: begin
          jw = rand_weight(); jv = rand_weight(); sm = 2'($urandom_range(0, 3));
          pr = rand_prec();
        end
      endcase
      write_reg(REG_JUMP_WEIGHT, {3'($urandom_range(0, 7)), jw});
      write_reg(REG_JUMP_PER_VERTEX, {3'($urandom_range(0, 7)), jv});
      write_reg(REG_SCHED_MODE, {30'($urandom()), sm});
      write_reg(REG_TARGET_PREC, pr);
      write_reg(CFG_IDX_W'($urandom_range(4, 15)), VALUE_W'($urandom()));

      phase_start = items_sent;
      if (phase == 3) send_vertex(1'b1);
      while (items_sent - phase_start < ITEMS_PER_PHASE) send_vertex(1'b0);
      drain();
    end

    $display("Checked %0d new-value beats and %0d out-edge beats (%0d scheduled) from %0d items,",
             value_beats, edge_beats, scheduled_beats, items_sent);
    $display("under reset registers and %0d further settings, all four scheduling rules.",
             PHASES);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
